// ----- rtl/xcfr_pkg.sv -----
// Shared types and constants of the XOR-checked frame receiver.
`default_nettype none

package xcfr_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned OUT_DATA_W = 32;
    // Wide enough for 5 + length byte and for any byte count.
    localparam int unsigned SUM_W      = 10;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'h08;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h06;
    localparam logic [4:0] MAX_PAYLOAD_RST   = 5'd30;
    localparam logic [4:0] HARD_PAYLOAD_LIMIT = 5'd30;
    localparam logic [SUM_W-1:0] MIN_FRAME   = 10'd5;
    localparam logic [SUM_W-1:0] HDR_BYTES   = 10'd4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_SHORT   = 3'd1,
        STAT_BAD_HDR = 3'd2,
        STAT_TOO_BIG = 3'd3,
        STAT_TRUNC   = 3'd4,
        STAT_CKSUM   = 3'd5
    } frame_status_t;

    typedef enum logic [2:0] {
        ST_RECV,
        ST_EVAL,
        ST_FETCH,
        ST_PAYLOAD,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic eval;
        logic load_payload;
        logic load_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_ok_nz;   // frame accepted with a non-empty payload
        logic last_payload;  // current read index is the final payload byte
        logic out_free;      // output register can take an item this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/xcfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module xcfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/xcfr_ctrl.sv -----
// Controller state machine: packet reception, frame check and result readout.
`default_nettype none

module xcfr_ctrl
    import xcfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd,
    output logic            s_tready
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV: begin
                if (s_tvalid && s_tlast) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = sts.frame_ok_nz ? ST_FETCH : ST_STATUS;
            end
            ST_FETCH: begin
                state_next = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (sts.out_free) state_next = sts.last_payload ? ST_STATUS : ST_FETCH;
            end
            ST_STATUS: begin
                if (sts.out_free) state_next = ST_RECV;
            end
            default: state_next = ST_RECV;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_RECV:    s_tready         = 1'b1;
            ST_EVAL:    cmd.eval         = 1'b1;
            ST_FETCH:   ;
            ST_PAYLOAD: cmd.load_payload = sts.out_free;
            ST_STATUS:  cmd.load_status  = sts.out_free;
            default:    ;
        endcase
    end

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_payload || cmd.load_status) |-> sts.out_free)
        else $error("item loaded into busy output register");

    a_eop_goes_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_EVAL))
        else $error("end of packet not followed by frame check");

    a_status_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_status |=> s_tready)
        else $error("input not reopened after status item");

endmodule

`default_nettype wire

// ----- rtl/xcfr_dpath.sv -----
// Datapath: config registers, packet capture, frame check and output register.
`default_nettype none

module xcfr_dpath
    import xcfr_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    // input item
    input  wire logic                  in_accept,
    input  wire logic [7:0]            rx_byte,
    // RAM
    output logic                       ram_we,
    output logic [$clog2(PACKET_BYTES)-1:0] ram_waddr,
    output logic [7:0]                 ram_wdata,
    output logic [$clog2(PACKET_BYTES)-1:0] ram_raddr,
    input  wire logic [7:0]            ram_rdata,
    // controller
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 sts,
    // result item
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int unsigned CW = $clog2(PACKET_BYTES);
    localparam logic [CW-1:0] KEEP_MAX = CW'(PACKET_BYTES - 1);

    // Config registers
    logic [7:0] header_first_reg, header_second_reg;
    logic [4:0] max_payload_reg;
    logic [1:0] cfg_idx;
    logic       cfg_wr;

    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            max_payload_reg   <= MAX_PAYLOAD_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HEADER_FIRST:  header_first_reg  <= pwdata[7:0];
                REG_HEADER_SECOND: header_second_reg <= pwdata[7:0];
                REG_MAX_PAYLOAD:   max_payload_reg   <= pwdata[4:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_HEADER_FIRST:  prdata = {24'd0, header_first_reg};
            REG_HEADER_SECOND: prdata = {24'd0, header_second_reg};
            REG_MAX_PAYLOAD:   prdata = {27'd0, max_payload_reg};
            default:           prdata = '0;
        endcase
    end

    // Packet capture: header fields and checksum are tracked as bytes arrive
    logic [CW-1:0]    byte_count_reg;
    logic [7:0]       hdr0_reg, hdr1_reg, sender_reg, len_reg, xor_reg, chk_reg;
    logic [7:0]       last_sender_reg;
    logic             store_en;
    logic [SUM_W-1:0] idx_w, xor_end;
    logic             in_xor, is_chk;

    assign store_en = in_accept && (byte_count_reg < KEEP_MAX);
    assign idx_w    = SUM_W'(byte_count_reg);
    assign xor_end  = SUM_W'(len_reg) + HDR_BYTES;
    assign in_xor   = (idx_w < HDR_BYTES) || (idx_w < xor_end);
    assign is_chk   = (idx_w >= HDR_BYTES) && (idx_w == xor_end);

    assign ram_we    = store_en;
    assign ram_waddr = byte_count_reg;
    assign ram_wdata = rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else if (cmd.eval) begin
            byte_count_reg <= '0;
        end else if (store_en) begin
            byte_count_reg <= byte_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            if (byte_count_reg == CW'(0)) hdr0_reg   <= rx_byte;
            if (byte_count_reg == CW'(1)) hdr1_reg   <= rx_byte;
            if (byte_count_reg == CW'(2)) sender_reg <= rx_byte;
            if (byte_count_reg == CW'(3)) len_reg    <= rx_byte;
            if (byte_count_reg == CW'(0)) begin
                xor_reg <= rx_byte;
            end else if (in_xor) begin
                xor_reg <= xor_reg ^ rx_byte;
            end
            if (is_chk) chk_reg <= rx_byte;
        end
    end

    // Frame check
    logic [4:0]    limit;
    frame_status_t eval_code;

    assign limit = (max_payload_reg > HARD_PAYLOAD_LIMIT) ? HARD_PAYLOAD_LIMIT
                                                          : max_payload_reg;

    always_comb begin
        priority if (idx_w < MIN_FRAME) begin
            eval_code = STAT_SHORT;
        end else if (hdr0_reg != header_first_reg || hdr1_reg != header_second_reg) begin
            eval_code = STAT_BAD_HDR;
        end else if (len_reg > {3'd0, limit}) begin
            eval_code = STAT_TOO_BIG;
        end else if ((SUM_W'(len_reg) + MIN_FRAME) > idx_w) begin
            eval_code = STAT_TRUNC;
        end else if (xor_reg != chk_reg) begin
            eval_code = STAT_CKSUM;
        end else begin
            eval_code = STAT_OK;
        end
    end

    frame_status_t status_reg;
    logic [4:0]    msg_len_reg;
    logic [4:0]    rd_idx_reg;
    logic [8:0]    raddr_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sender_reg <= '0;
        end else if (cmd.eval && eval_code == STAT_OK) begin
            last_sender_reg <= sender_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            status_reg  <= eval_code;
            msg_len_reg <= (eval_code == STAT_OK) ? len_reg[4:0] : 5'd0;
            rd_idx_reg  <= '0;
        end else if (cmd.load_payload) begin
            rd_idx_reg  <= rd_idx_reg + 1'b1;
        end
    end

    assign raddr_w   = 9'(rd_idx_reg) + 9'(HDR_BYTES);
    assign ram_raddr = raddr_w[CW-1:0];

    // Output register
    logic       out_valid_reg;
    logic       out_kind_reg, out_last_reg;
    logic [7:0] out_byte_reg, out_sender_reg;
    logic [4:0] out_idx_reg, out_len_reg;
    logic [2:0] out_status_reg;

    assign sts.out_free     = !out_valid_reg || m_tready;
    assign sts.frame_ok_nz  = (eval_code == STAT_OK) && (len_reg != 8'd0);
    assign sts.last_payload = ((rd_idx_reg + 5'd1) == msg_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_payload || cmd.load_status) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_payload) begin
            out_kind_reg   <= 1'b0;
            out_byte_reg   <= ram_rdata;
            out_idx_reg    <= rd_idx_reg;
            out_status_reg <= STAT_OK;
            out_sender_reg <= last_sender_reg;
            out_len_reg    <= msg_len_reg;
            out_last_reg   <= 1'b0;
        end else if (cmd.load_status) begin
            out_kind_reg   <= 1'b1;
            out_byte_reg   <= 8'd0;
            out_idx_reg    <= 5'd0;
            out_status_reg <= status_reg;
            out_sender_reg <= last_sender_reg;
            out_len_reg    <= msg_len_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_len_reg, out_sender_reg, out_status_reg,
                       out_idx_reg, out_byte_reg};

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_payload |-> (rd_idx_reg < msg_len_reg))
        else $error("payload read past message length");

    a_reject_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_status && (status_reg != STAT_OK) |-> (msg_len_reg == 5'd0))
        else $error("rejected frame carries a length");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= KEEP_MAX)
        else $error("byte count beyond packet store");

endmodule

`default_nettype wire

// ----- rtl/xor_checked_frame_receiver_top.sv -----
// Top level of the XOR-checked frame receiver.
// Takes one packet byte per item (tlast on the final byte) at one item per cycle and keeps
// the first PACKET_BYTES-1 bytes in a packet RAM. After the final byte the input stalls:
// the frame is checked, then each payload byte is fetched by a registered RAM read and then
// loaded into the output register, and after the last one the status item is loaded. A
// rejected frame yields only the status item. Results leave through an output register,
// so the next packet's bytes are taken while the status item still waits.
`default_nettype none

module xor_checked_frame_receiver_top
    import xcfr_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // rx_byte
    input  wire logic                  s_tlast,   // end_of_packet
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // payload_byte[7:0], payload_index[12:8], status[15:13], sender_id[23:16],
    // message_length[28:24], zero[31:29]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,   // kind
    output logic                       m_tlast    // last_of_run
);

    localparam int unsigned AW = $clog2(PACKET_BYTES);

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign pready = 1'b1;

    xcfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    xcfr_dpath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .in_accept (s_tvalid && s_tready),
        .rx_byte   (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    xcfr_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
